FILE: rtl/core/block_segment_allocator_core_assert.svh
// ----------------------------------------------------------------------------
// Block segment allocator assertion macros
// Shared wrappers for the concurrent checks on the allocator core.
// ----------------------------------------------------------------------------
`ifndef BLOCK_SEGMENT_ALLOCATOR_CORE_ASSERT_SVH
`define BLOCK_SEGMENT_ALLOCATOR_CORE_ASSERT_SVH

// Check a property on every rising edge outside reset
`define BSA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check a property on every rising edge, reset included
`define BSA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/bsa_pkg.sv
// ----------------------------------------------------------------------------
// Block segment allocator package
// Command and status codes and the beat types of both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bsa_pkg;

    // Command codes
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // Status codes
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_NOMEM   = 2'd1;
    localparam logic [1:0] STATUS_BADADDR = 2'd2;

    // Log2 of the block size in bytes
    localparam int BLOCK_SHIFT = 6;

    typedef struct packed {
        logic        command;
        logic [17:0] request_bytes;
        logic [17:0] free_offset;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [17:0] payload_offset;
        logic [12:0] used_blocks;
        logic [12:0] section_count;
        logic [27:0] used_bytes;
    } out_item_t;

endpackage

`default_nettype wire

FILE: rtl/core/bsa_ram.sv
// ----------------------------------------------------------------------------
// Block segment allocator RAM
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write, then register the read word
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/core/block_segment_allocator_core.sv
// ----------------------------------------------------------------------------
// Block segment allocator core
// Best-fit allocator over 64-byte blocks with a sorted free list in RAM.
// ----------------------------------------------------------------------------
// Each header access is a read through ST_READ plus a use state in one RAM.
//   Allocate: check room, walk list nodes to the fit, write the new section, then
//   unlink the host and re-sort it when the host keeps free blocks.
//   Free: walk sections from root to target, unlink the target and the previous
//   section where listed, merge and re-sort. Rejects come early or after a walk.
// Commands: one at a time; the next is taken once the result is in the
//   output register. Reset and a size write rebuild via ST_BUILD0 and ST_BUILD1.
`timescale 1ns / 1ps
`default_nettype none

module block_segment_allocator_core
    import bsa_pkg::*;
#(
    parameter int NUM_BLOCKS    = 4096,
    parameter int HEADER_BLOCKS = 1,
    parameter int ROOT_BLOCKS   = 2,
    parameter int ROOT_BYTES    = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [12:0] cfg_wr_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire in_item_t    s_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output out_item_t        m_data
);

    localparam int IW    = $clog2(NUM_BLOCKS);
    localparam int CW    = IW + 1;
    localparam int WW    = (CW > 14) ? CW + 1 : 15;
    localparam int OW    = (IW + BLOCK_SHIFT > 18) ? IW + BLOCK_SHIFT : 18;
    localparam int MINB  = ROOT_BLOCKS + HEADER_BLOCKS + 1;

    typedef struct packed {
        logic [IW-1:0] prev;
        logic [IW-1:0] less;
        logic [IW-1:0] more;
        logic [CW-1:0] used;
        logic [CW-1:0] spare;
        logic [17:0]   req;
    } ent_t;

    typedef enum logic [25:0] {
        ST_IDLE      = 26'h0000001,
        ST_BUILD0    = 26'h0000002,
        ST_BUILD1    = 26'h0000004,
        ST_READ      = 26'h0000008,
        ST_FIN       = 26'h0000010,
        ST_A_START   = 26'h0000020,
        ST_A_HEAD    = 26'h0000040,
        ST_A_WALK    = 26'h0000080,
        ST_A_NXT     = 26'h0000100,
        ST_A_SEC     = 26'h0000200,
        ST_A_POS     = 26'h0000400,
        ST_A_AFTER   = 26'h0000800,
        ST_F_START   = 26'h0001000,
        ST_F_WALK    = 26'h0002000,
        ST_F_SEC     = 26'h0004000,
        ST_F_NXT     = 26'h0008000,
        ST_F_PRVRD   = 26'h0010000,
        ST_F_PRV     = 26'h0020000,
        ST_RM_L      = 26'h0040000,
        ST_RM_M      = 26'h0080000,
        ST_INS_START = 26'h0100000,
        ST_INS_HEAD  = 26'h0200000,
        ST_INS_WALK  = 26'h0400000,
        ST_INS_LN    = 26'h0800000,
        ST_INS_N     = 26'h1000000,
        ST_INS_S     = 26'h2000000
    } state_t;

    function automatic logic [CW-1:0] seg_clamp(input logic [12:0] t);
        logic [CW-1:0] r;
        if (int'(t) < MINB) begin
            r = CW'(MINB);
        end else if (int'(t) > NUM_BLOCKS) begin
            r = CW'(NUM_BLOCKS);
        end else begin
            r = CW'(t);
        end
        return r;
    endfunction

    state_t        state_reg, state_next;
    state_t        after_reg, after_next;
    state_t        rm_ret_reg, rm_ret_next;
    logic [IW-1:0] addr_reg, addr_next;
    logic [CW-1:0] seg_reg, seg_next;
    logic [IW-1:0] last_reg, last_next;
    logic [17:0]   bytes_reg, bytes_next;
    logic [17:0]   off_reg, off_next;
    logic [CW-1:0] num_reg, num_next;
    logic [IW-1:0] pos_reg, pos_next;
    ent_t          ent_reg, ent_next;
    logic [CW-1:0] pspare_reg, pspare_next;
    logic [IW-1:0] sec_reg, sec_next;
    logic [IW-1:0] rl_reg, rl_next;
    logic [IW-1:0] rm_reg, rm_next;
    logic [IW-1:0] ins_s_reg, ins_s_next;
    logic [CW-1:0] ins_f_reg, ins_f_next;
    logic          tie_reg, tie_next;
    logic [IW-1:0] ln_reg, ln_next;
    logic [IW-1:0] n_reg, n_next;
    logic [IW-1:0] hdr_reg, hdr_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [1:0]    status_reg, status_next;
    logic [17:0]   poff_reg, poff_next;
    logic [CW-1:0] blocks_reg, blocks_next;
    logic [CW-1:0] live_reg, live_next;
    logic [27:0]   used_bytes_reg, used_bytes_next;
    logic          m_valid_reg, m_valid_next;
    out_item_t     m_data_reg, m_data_next;

    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    ent_t          wr_ent;
    ent_t          rd_ent;
    logic [$bits(ent_t)-1:0] ram_rdata;

    // Scratch values for the sequencer
    logic [13:0]   num_full;
    logic [WW-1:0] free_cnt;
    logic [CW:0]   step;
    logic [CW:0]   idx_sum;
    logic [CW-1:0] idx_chk;
    logic [11:0]   blk;
    logic          chk_ok;
    logic          ins_brk;
    logic [CW-1:0] new_spare;

    bsa_ram #(
        .WIDTH ($bits(ent_t)),
        .DEPTH (NUM_BLOCKS)
    ) u_hdr_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (wr_ent),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    assign rd_ent  = ent_t'(ram_rdata);
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Blocks needed: header plus payload blocks, at least one payload block
    always_comb begin
        if (bytes_reg == 18'd0) begin
            num_full = 14'(HEADER_BLOCKS + 1);
        end else begin
            num_full = 14'(HEADER_BLOCKS) + 14'((19'(bytes_reg) + 19'd63) >> BLOCK_SHIFT);
        end
        free_cnt  = WW'(seg_reg) - WW'(blocks_reg);
        blk       = off_reg[17:6];
        step      = (CW+1)'(rd_ent.used) + (CW+1)'(rd_ent.spare);
        idx_sum   = (CW+1)'(idx_reg) + step;
        idx_chk   = (step == '0) ? idx_reg : CW'(idx_sum);
        chk_ok    = (idx_chk == CW'(hdr_reg)) && (hdr_reg != '0) && (hdr_reg < last_reg);
        ins_brk   = (n_reg == last_reg) ||
                    (tie_reg ? (rd_ent.spare > ins_f_reg) : (rd_ent.spare >= ins_f_reg));
        new_spare = rd_ent.spare + ent_reg.used + ent_reg.spare;
    end

    // Sequencer: every header access reads through ST_READ, then uses or modifies
    always_comb begin
        state_next      = state_reg;
        after_next      = after_reg;
        rm_ret_next     = rm_ret_reg;
        addr_next       = addr_reg;
        seg_next        = seg_reg;
        last_next       = last_reg;
        bytes_next      = bytes_reg;
        off_next        = off_reg;
        num_next        = num_reg;
        pos_next        = pos_reg;
        ent_next        = ent_reg;
        pspare_next     = pspare_reg;
        sec_next        = sec_reg;
        rl_next         = rl_reg;
        rm_next         = rm_reg;
        ins_s_next      = ins_s_reg;
        ins_f_next      = ins_f_reg;
        tie_next        = tie_reg;
        ln_next         = ln_reg;
        n_next          = n_reg;
        hdr_next        = hdr_reg;
        idx_next        = idx_reg;
        status_next     = status_reg;
        poff_next       = poff_reg;
        blocks_next     = blocks_reg;
        live_next       = live_reg;
        used_bytes_next = used_bytes_reg;
        m_valid_next    = m_valid_reg & ~m_ready;
        m_data_next     = m_data_reg;
        ram_we          = 1'b0;
        ram_waddr       = addr_reg;
        wr_ent          = rd_ent;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    bytes_next  = s_data.request_bytes;
                    off_next    = s_data.free_offset;
                    status_next = STATUS_OK;
                    poff_next   = '0;
                    state_next  = (s_data.command == CMD_FREE) ? ST_F_START : ST_A_START;
                end
            end
            ST_BUILD0: begin
                ram_we          = 1'b1;
                ram_waddr       = '0;
                wr_ent.prev     = '0;
                wr_ent.less     = last_reg;
                wr_ent.more     = last_reg;
                wr_ent.used     = CW'(ROOT_BLOCKS);
                wr_ent.spare    = seg_reg - CW'(ROOT_BLOCKS + HEADER_BLOCKS);
                wr_ent.req      = 18'(ROOT_BYTES);
                blocks_next     = CW'(ROOT_BLOCKS + HEADER_BLOCKS);
                live_next       = CW'(2);
                used_bytes_next = 28'(ROOT_BYTES);
                state_next      = ST_BUILD1;
            end
            ST_BUILD1: begin
                ram_we     = 1'b1;
                ram_waddr  = last_reg;
                wr_ent     = '0;
                state_next = ST_IDLE;
            end
            ST_READ: begin
                state_next = after_reg;
            end
            ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next                = 1'b1;
                    m_data_next.status          = status_reg;
                    m_data_next.payload_offset  = poff_reg;
                    m_data_next.used_blocks     = 13'(blocks_reg);
                    m_data_next.section_count   = 13'(live_reg);
                    m_data_next.used_bytes      = used_bytes_reg;
                    state_next                  = ST_IDLE;
                end
            end
            // Allocate: check room, then walk the list from the last section
            ST_A_START: begin
                num_next = CW'(num_full);
                if (WW'(num_full) > free_cnt) begin
                    status_next = STATUS_NOMEM;
                    state_next  = ST_FIN;
                end else begin
                    addr_next  = last_reg;
                    after_next = ST_A_HEAD;
                    state_next = ST_READ;
                end
            end
            ST_A_HEAD: begin
                pos_next   = rd_ent.more;
                addr_next  = rd_ent.more;
                after_next = ST_A_WALK;
                state_next = ST_READ;
            end
            ST_A_WALK: begin
                if (pos_reg == last_reg) begin
                    status_next = STATUS_NOMEM;
                    state_next  = ST_FIN;
                end else if (rd_ent.spare >= num_reg) begin
                    ent_next    = rd_ent;
                    pspare_next = rd_ent.spare - num_reg;
                    addr_next   = IW'(CW'(pos_reg) + rd_ent.used + rd_ent.spare);
                    sec_next    = IW'(CW'(pos_reg) + rd_ent.used + rd_ent.spare - num_reg);
                    after_next  = ST_A_NXT;
                    state_next  = ST_READ;
                end else begin
                    pos_next   = rd_ent.more;
                    addr_next  = rd_ent.more;
                    after_next = ST_A_WALK;
                    state_next = ST_READ;
                end
            end
            ST_A_NXT: begin
                ram_we      = 1'b1;
                wr_ent.prev = sec_reg;
                state_next  = ST_A_SEC;
            end
            ST_A_SEC: begin
                ram_we          = 1'b1;
                ram_waddr       = sec_reg;
                wr_ent.prev     = pos_reg;
                wr_ent.less     = '0;
                wr_ent.more     = '0;
                wr_ent.used     = num_reg;
                wr_ent.spare    = '0;
                wr_ent.req      = bytes_reg;
                blocks_next     = blocks_reg + num_reg;
                live_next       = live_reg + CW'(1);
                used_bytes_next = used_bytes_reg + 28'(bytes_reg);
                poff_next       = 18'({CW'(sec_reg) + CW'(HEADER_BLOCKS), 6'b0});
                state_next      = ST_A_POS;
            end
            ST_A_POS: begin
                ram_we       = 1'b1;
                ram_waddr    = pos_reg;
                wr_ent       = ent_reg;
                wr_ent.spare = pspare_reg;
                rl_next      = ent_reg.less;
                rm_next      = ent_reg.more;
                addr_next    = ent_reg.less;
                rm_ret_next  = ST_A_AFTER;
                after_next   = ST_RM_L;
                state_next   = ST_READ;
            end
            ST_A_AFTER: begin
                if (pspare_reg != '0) begin
                    ins_s_next = pos_reg;
                    ins_f_next = pspare_reg;
                    tie_next   = 1'b1;
                    state_next = ST_INS_START;
                end else begin
                    state_next = ST_FIN;
                end
            end
            // Free: check the offset, then walk sections in block order
            ST_F_START: begin
                if ((off_reg[5:0] != 6'd0) ||
                    (OW'(off_reg) > OW'({last_reg, 6'b0})) ||
                    (blk <= 12'(HEADER_BLOCKS))) begin
                    status_next = STATUS_BADADDR;
                    state_next  = ST_FIN;
                end else begin
                    hdr_next   = IW'(blk - 12'(HEADER_BLOCKS));
                    idx_next   = '0;
                    addr_next  = '0;
                    after_next = ST_F_WALK;
                    state_next = ST_READ;
                end
            end
            ST_F_WALK: begin
                if ((step != '0) && (idx_sum < (CW+1)'(hdr_reg))) begin
                    idx_next   = CW'(idx_sum);
                    addr_next  = IW'(idx_sum);
                    after_next = ST_F_WALK;
                    state_next = ST_READ;
                end else if (chk_ok) begin
                    addr_next  = hdr_reg;
                    after_next = ST_F_SEC;
                    state_next = ST_READ;
                end else begin
                    status_next = STATUS_BADADDR;
                    state_next  = ST_FIN;
                end
            end
            ST_F_SEC: begin
                ram_we          = 1'b1;
                wr_ent.used     = '0;
                wr_ent.spare    = '0;
                ent_next        = rd_ent;
                blocks_next     = blocks_reg - rd_ent.used;
                live_next       = live_reg - CW'(1);
                used_bytes_next = used_bytes_reg - 28'(rd_ent.req);
                addr_next       = IW'(CW'(hdr_reg) + rd_ent.used + rd_ent.spare);
                after_next      = ST_F_NXT;
                state_next      = ST_READ;
            end
            ST_F_NXT: begin
                ram_we      = 1'b1;
                wr_ent.prev = ent_reg.prev;
                if (ent_reg.spare != '0) begin
                    rl_next     = ent_reg.less;
                    rm_next     = ent_reg.more;
                    addr_next   = ent_reg.less;
                    rm_ret_next = ST_F_PRVRD;
                    after_next  = ST_RM_L;
                    state_next  = ST_READ;
                end else begin
                    state_next = ST_F_PRVRD;
                end
            end
            ST_F_PRVRD: begin
                addr_next  = ent_reg.prev;
                after_next = ST_F_PRV;
                state_next = ST_READ;
            end
            ST_F_PRV: begin
                ram_we       = 1'b1;
                wr_ent.spare = new_spare;
                ins_s_next   = addr_reg;
                ins_f_next   = new_spare;
                tie_next     = 1'b0;
                if (rd_ent.spare != '0) begin
                    rl_next     = rd_ent.less;
                    rm_next     = rd_ent.more;
                    addr_next   = rd_ent.less;
                    rm_ret_next = ST_INS_START;
                    after_next  = ST_RM_L;
                    state_next  = ST_READ;
                end else begin
                    state_next = ST_INS_START;
                end
            end
            // Unlink: bridge the two neighbors of a listed section
            ST_RM_L: begin
                ram_we      = 1'b1;
                wr_ent.more = rm_reg;
                addr_next   = rm_reg;
                after_next  = ST_RM_M;
                state_next  = ST_READ;
            end
            ST_RM_M: begin
                ram_we      = 1'b1;
                wr_ent.less = rl_reg;
                state_next  = rm_ret_reg;
            end
            // Sorted insert: walk from the last section to the first larger one (equal or larger on a free)
            ST_INS_START: begin
                addr_next  = last_reg;
                after_next = ST_INS_HEAD;
                state_next = ST_READ;
            end
            ST_INS_HEAD: begin
                n_next     = rd_ent.more;
                addr_next  = rd_ent.more;
                after_next = ST_INS_WALK;
                state_next = ST_READ;
            end
            ST_INS_WALK: begin
                if (ins_brk) begin
                    ln_next    = rd_ent.less;
                    addr_next  = rd_ent.less;
                    after_next = ST_INS_LN;
                end else begin
                    n_next     = rd_ent.more;
                    addr_next  = rd_ent.more;
                    after_next = ST_INS_WALK;
                end
                state_next = ST_READ;
            end
            ST_INS_LN: begin
                ram_we      = 1'b1;
                wr_ent.more = ins_s_reg;
                addr_next   = n_reg;
                after_next  = ST_INS_N;
                state_next  = ST_READ;
            end
            ST_INS_N: begin
                ram_we      = 1'b1;
                wr_ent.less = ins_s_reg;
                addr_next   = ins_s_reg;
                after_next  = ST_INS_S;
                state_next  = ST_READ;
            end
            ST_INS_S: begin
                ram_we      = 1'b1;
                wr_ent.less = ln_reg;
                wr_ent.more = n_reg;
                state_next  = ST_FIN;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Rebuild the empty segment on a size write
        if (cfg_wr_en) begin
            seg_next   = seg_clamp(cfg_wr_data);
            last_next  = IW'(seg_clamp(cfg_wr_data) - CW'(HEADER_BLOCKS));
            state_next = ST_BUILD0;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_BUILD0;
            after_reg      <= ST_IDLE;
            rm_ret_reg     <= ST_IDLE;
            seg_reg        <= seg_clamp(13'd4096);
            last_reg       <= IW'(seg_clamp(13'd4096) - CW'(HEADER_BLOCKS));
            blocks_reg     <= CW'(ROOT_BLOCKS + HEADER_BLOCKS);
            live_reg       <= CW'(2);
            used_bytes_reg <= 28'(ROOT_BYTES);
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            after_reg      <= after_next;
            rm_ret_reg     <= rm_ret_next;
            seg_reg        <= seg_next;
            last_reg       <= last_next;
            blocks_reg     <= blocks_next;
            live_reg       <= live_next;
            used_bytes_reg <= used_bytes_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Working and payload registers
    always_ff @(posedge aclk) begin
        addr_reg   <= addr_next;
        bytes_reg  <= bytes_next;
        off_reg    <= off_next;
        num_reg    <= num_next;
        pos_reg    <= pos_next;
        ent_reg    <= ent_next;
        pspare_reg <= pspare_next;
        sec_reg    <= sec_next;
        rl_reg     <= rl_next;
        rm_reg     <= rm_next;
        ins_s_reg  <= ins_s_next;
        ins_f_reg  <= ins_f_next;
        tie_reg    <= tie_next;
        ln_reg     <= ln_next;
        n_reg      <= n_next;
        hdr_reg    <= hdr_next;
        idx_reg    <= idx_next;
        status_reg <= status_next;
        poff_reg   <= poff_next;
        m_data_reg <= m_data_next;
    end

endmodule

`default_nettype wire

FILE: rtl/core/bsa_checker.sv
// ----------------------------------------------------------------------------
// Block segment allocator checker
// Port-level checks on the allocator core, bound into the core module.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "block_segment_allocator_core_assert.svh"

module bsa_checker
    import bsa_pkg::*;
(
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      s_valid,
    input wire logic      s_ready,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire out_item_t m_data
);

    // Hold a stalled result beat
    `BSA_ASSERT(a_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_data), "result beat changed while stalled")

    // Report no offset on a failed command
    `BSA_ASSERT(a_fail_zero, aclk, aresetn, m_valid && (m_data.status != STATUS_OK) |-> m_data.payload_offset == 18'd0, "offset on failed command")

    // Place payloads on block boundaries
    `BSA_ASSERT(a_aligned, aclk, aresetn, m_valid |-> m_data.payload_offset[5:0] == 6'd0, "payload offset not block aligned")

    // Take one command at a time
    `BSA_ASSERT(a_one_cmd, aclk, aresetn, s_valid && s_ready |=> !s_ready, "command taken while busy")

    // Drop result and hold off commands right after reset
    `BSA_ASSERT_ALWAYS(a_reset, aclk, !aresetn |=> !m_valid && !s_ready, "not quiet after reset")

endmodule

bind block_segment_allocator_core bsa_checker u_bsa_checker (.*);

`default_nettype wire

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// Block segment allocator testbench
// Drives allocate and free commands through the valid/ready channels and
// checks every result beat against a best-fit model of the segment, over
// several segment sizes and handshake idling mixes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import bsa_pkg::*;

class alloc_scoreboard;
    localparam int NB = 4096;
    localparam int HDR = 1;
    localparam int ROOTB = 2;
    localparam int ROOTY = 64;

    int unsigned seg_blocks, last_idx;
    int unsigned prev_of[NB], less_of[NB], more_of[NB];
    int unsigned used_of[NB], spare_of[NB], req_of[NB];
    int unsigned blocks_used, sections, bytes_used;
    out_item_t expected_q[$];
    int errors;
    // payload offsets of live sections, used to steer frees
    int unsigned live_offsets[$];

    function int unsigned clampi(int unsigned v);
        return v < NB ? v : 0;
    endfunction

    function void rebuild(int unsigned total);
        int unsigned t;
        t = total;
        if (t < ROOTB + HDR + 1) t = ROOTB + HDR + 1;
        if (t > NB) t = NB;
        seg_blocks = t;
        last_idx = t - HDR;
        for (int i = 0; i < NB; i++) begin
            prev_of[i] = 0; less_of[i] = 0; more_of[i] = 0;
            used_of[i] = 0; spare_of[i] = 0; req_of[i] = 0;
        end
        used_of[0] = ROOTB;
        spare_of[0] = t - (ROOTB + HDR);
        req_of[0] = ROOTY;
        less_of[0] = last_idx;
        more_of[0] = last_idx;
        blocks_used = ROOTB + HDR;
        sections = 2;
        bytes_used = ROOTY;
        live_offsets.delete();
    endfunction

    function void unlink(int unsigned s);
        int unsigned l, m;
        l = clampi(less_of[clampi(s)]);
        m = clampi(more_of[clampi(s)]);
        more_of[l] = m;
        less_of[m] = l;
    endfunction

    function void place(int unsigned s, bit after_ties);
        int unsigned f, n, g, guard, l;
        f = spare_of[clampi(s)];
        n = clampi(more_of[clampi(last_idx)]);
        guard = 0;
        while (n != last_idx && guard < NB) begin
            g = spare_of[n];
            if (after_ties ? (g > f) : (g >= f)) break;
            n = clampi(more_of[n]);
            guard++;
        end
        l = less_of[n];
        more_of[clampi(l)] = s;
        less_of[clampi(n)] = s;
        less_of[clampi(s)] = l;
        more_of[clampi(s)] = n;
    endfunction

    function out_item_t pack_result(logic [1:0] st, int unsigned off);
        out_item_t r;
        r.status = st;
        r.payload_offset = off[17:0];
        r.used_blocks = blocks_used[12:0];
        r.section_count = sections[12:0];
        r.used_bytes = bytes_used[27:0];
        return r;
    endfunction

    function out_item_t allocate(int unsigned bytes);
        int unsigned num, pos, nxt, sec, guard;
        num = bytes ? HDR + (bytes + 63) / 64 : HDR + 1;
        if (num > seg_blocks - blocks_used) return pack_result(STATUS_NOMEM, 0);
        pos = clampi(more_of[clampi(last_idx)]);
        guard = 0;
        while (pos != last_idx && spare_of[pos] < num && guard < NB) begin
            pos = clampi(more_of[pos]);
            guard++;
        end
        if (pos == last_idx || spare_of[pos] < num) return pack_result(STATUS_NOMEM, 0);
        nxt = clampi(pos + used_of[pos] + spare_of[pos]);
        sec = clampi(nxt - num);
        prev_of[nxt] = sec;
        prev_of[sec] = pos;
        less_of[sec] = 0;
        more_of[sec] = 0;
        used_of[sec] = num;
        spare_of[sec] = 0;
        req_of[sec] = bytes;
        spare_of[pos] -= num;
        unlink(pos);
        if (spare_of[pos] != 0) place(pos, 1'b1);
        bytes_used = (bytes_used + bytes) & 28'hFFFFFFF;
        blocks_used += num;
        sections++;
        live_offsets.push_back((sec + HDR) * 64);
        return pack_result(STATUS_OK, (sec + HDR) * 64);
    endfunction

    function out_item_t release_section(int unsigned off);
        int unsigned hdr, idx, stp, sec, prv, nxt, guard;
        if ((off % 64) != 0 || off > last_idx * 64 || off / 64 <= HDR)
            return pack_result(STATUS_BADADDR, 0);
        hdr = off / 64 - HDR;
        idx = 0;
        guard = 0;
        while (idx < hdr && guard < NB) begin
            stp = used_of[clampi(idx)] + spare_of[clampi(idx)];
            if (stp == 0) break;
            idx += stp;
            guard++;
        end
        if (idx != hdr || hdr == 0 || hdr >= last_idx) return pack_result(STATUS_BADADDR, 0);
        sec = clampi(hdr);
        prv = clampi(prev_of[sec]);
        nxt = clampi(sec + used_of[sec] + spare_of[sec]);
        prev_of[nxt] = prv;
        if (spare_of[sec] != 0) unlink(sec);
        if (spare_of[prv] != 0) unlink(prv);
        spare_of[prv] += used_of[sec] + spare_of[sec];
        place(prv, 1'b0);
        bytes_used = (bytes_used - req_of[sec]) & 28'hFFFFFFF;
        blocks_used -= used_of[sec];
        sections--;
        used_of[sec] = 0;
        spare_of[sec] = 0;
        foreach (live_offsets[i])
            if (live_offsets[i] == off) begin
                live_offsets.delete(i);
                break;
            end
        return pack_result(STATUS_OK, 0);
    endfunction

    // Note an accepted command beat and queue its result
    function void note_command(in_item_t c);
        if (c.command == CMD_FREE) expected_q.push_back(release_section(c.free_offset));
        else expected_q.push_back(allocate(c.request_bytes));
    endfunction

    // Compare a result beat with the oldest queued result
    function void check_result(out_item_t got);
        out_item_t exp;
        if (expected_q.size() == 0) begin
            $display("%0t: unexpected result beat %p", $time, got);
            errors++;
            return;
        end
        exp = expected_q.pop_front();
        if (got.status !== exp.status) begin
            $display("%0t: status exp %0d got %0d", $time, exp.status, got.status);
            errors++;
        end
        if (got.payload_offset !== exp.payload_offset) begin
            $display("%0t: payload_offset exp %0d got %0d", $time,
                     exp.payload_offset, got.payload_offset);
            errors++;
        end
        if (got.used_blocks !== exp.used_blocks) begin
            $display("%0t: used_blocks exp %0d got %0d", $time,
                     exp.used_blocks, got.used_blocks);
            errors++;
        end
        if (got.section_count !== exp.section_count) begin
            $display("%0t: section_count exp %0d got %0d", $time,
                     exp.section_count, got.section_count);
            errors++;
        end
        if (got.used_bytes !== exp.used_bytes) begin
            $display("%0t: used_bytes exp %0d got %0d", $time,
                     exp.used_bytes, got.used_bytes);
            errors++;
        end
    endfunction
endclass

module tb_top;
    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [12:0] cfg_wr_data;
    logic        s_valid;
    logic        s_ready;
    in_item_t    s_data;
    logic        m_valid;
    logic        m_ready;
    out_item_t   m_data;

    alloc_scoreboard board;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_off_cycles;

    block_segment_allocator_core u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Run limit: generous over the slowest walks with heavy stalls
    initial begin
        #1000ms;
        $display("tb_top: FAIL");
        $finish;
    end

    // Result side: stall at random or hold off for a counted stretch
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) board.check_result(m_data);
            if (hold_off_cycles > 0) begin
                hold_off_cycles <= hold_off_cycles - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Send one command beat, then idle at random before the next
    task automatic send_beat(in_item_t c);
        s_valid <= 1'b1;
        s_data <= c;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_command(c);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        end
    endtask

    task automatic send_alloc(int unsigned bytes);
        in_item_t c;
        c.command = CMD_ALLOC;
        c.request_bytes = bytes[17:0];
        c.free_offset = $urandom();
        send_beat(c);
    endtask

    task automatic send_free(int unsigned off);
        in_item_t c;
        c.command = CMD_FREE;
        c.request_bytes = $urandom();
        c.free_offset = off[17:0];
        send_beat(c);
    endtask

    // Drop valid, wait for all results, then let a late walk finish
    task automatic drain();
        s_valid <= 1'b0;
        while (board.expected_q.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
    endtask

    task automatic write_size(int unsigned total);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= total[12:0];
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        board.rebuild(total);
        @(posedge aclk);
    endtask

    // Mostly live frees and sized allocs, some junk offsets and huge sizes
    task automatic random_beats(int n);
        int unsigned r, sz;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < 40 && board.live_offsets.size() != 0) begin
                send_free(board.live_offsets[$urandom_range(board.live_offsets.size() - 1)]);
            end else if (r < 48) begin
                send_free($urandom_range(5) == 0 ? $urandom() : $urandom_range(4095) * 64);
            end else begin
                sz = $urandom_range(9);
                if (sz < 6) send_alloc($urandom_range(640));
                else if (sz < 9) send_alloc($urandom_range(8192));
                else send_alloc($urandom());
            end
        end
    endtask

    initial begin
        int unsigned sizes[6];
        board = new();
        board.rebuild(4096);
        board.errors = 0;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        s_valid = 1'b0;
        s_data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: size extremes, zero bytes, bad offsets, ties and merges
        send_alloc(0);
        send_alloc(1);
        send_alloc(64);
        send_alloc(65);
        send_alloc(262143);
        send_alloc(64);
        send_free(3 * 64);
        send_free(5 * 64);
        send_free(1);
        send_free(0);
        send_free(64);
        send_free(262143);
        send_free(4095 * 64);
        send_free(3 * 64);
        send_free(10 * 64);
        send_free(2 * 64);
        write_size(0);
        send_alloc(0);
        send_alloc(1);
        send_free(3 * 64);
        write_size(8191);
        send_alloc(4093 * 64 - 64);
        send_alloc(0);
        send_free(3 * 64);

        sizes = '{4096, 64, 5, 300, 4096, 1000};
        for (int ph = 0; ph < 6; ph++) begin
            write_size(sizes[ph]);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
                default: begin send_idle_pct = 7; recv_stall_pct = 7; end
            endcase
            if (ph == 4) hold_off_cycles = 3000;
            random_beats(255);
        end

        drain();
        if (board.errors == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end
endmodule
